// File: src/ptma_pkg.sv
// Shared types and constants for the presence table with miss aging.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ptma_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int ADDR_W   = 64;
    localparam int MISSES_W = 8;
    localparam int LIMIT_W  = 8;

    localparam logic [MISSES_W-1:0] MISSES_MAX    = '1;
    localparam logic [LIMIT_W-1:0]  MISS_LIMIT_RST = 8'd2;

    // request codes
    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_FOUND = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    // event codes
    localparam logic [1:0] EV_ATTACH = 2'd0;
    localparam logic [1:0] EV_DETACH = 2'd1;
    localparam logic [1:0] EV_DROP   = 2'd2;
    localparam logic [1:0] EV_DONE   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [MISSES_W-1:0] misses;
    } slot_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

endpackage

// File: src/ptma_mem.sv
// Slot store: address and miss count per slot, one write and one read port.
// Registered read data, held while no read is issued. Uses ptma_pkg.
`timescale 1ns / 1ps

module ptma_mem #(
    parameter int DEPTH = ptma_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  ptma_pkg::slot_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output ptma_pkg::slot_entry_t rd_data
);

    ptma_pkg::slot_entry_t slot_mem [DEPTH];
    ptma_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/ptma_ctrl.sv
// Scan sequencer: walks the slots through the store, read then modify/write,
// keeps the valid bits, the limit register and the output register. Uses ptma_pkg.
`timescale 1ns / 1ps

module ptma_ctrl #(
    parameter int DEPTH = ptma_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [ptma_pkg::ADDR_W-1:0]   device_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    event_res,
    output logic [ptma_pkg::ADDR_W-1:0]   event_address,
    output logic                          last,
    input  logic                          cfg_wr_en,
    input  logic [ptma_pkg::LIMIT_W-1:0]  cfg_wr_data,
    output logic                          mem_wr_en,
    output logic [IDX_W-1:0]              mem_wr_addr,
    output ptma_pkg::slot_entry_t         mem_wr_data,
    output logic                          mem_rd_en,
    output logic [IDX_W-1:0]              mem_rd_addr,
    input  ptma_pkg::slot_entry_t         mem_rd_data
);

    ptma_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             free_found_reg, free_found_next;
    logic [DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [ptma_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [1:0]       action_reg, action_next;
    logic [ptma_pkg::ADDR_W-1:0] addr_reg, addr_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_res_reg, out_res_next;
    logic [ptma_pkg::ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic             out_last_reg, out_last_next;

    logic in_accept;
    logic start;
    logic idx_last;
    logic cur_valid;
    logic hit;
    logic aged;
    logic emit_ok;

    assign in_accept = in_valid && (state_reg == ptma_pkg::ST_IDLE);
    // found with address zero and the unused code start nothing
    assign start     = in_accept && ((action == ptma_pkg::ACT_BEGIN)
                     || (action == ptma_pkg::ACT_END)
                     || ((action == ptma_pkg::ACT_FOUND) && (device_address != '0)));
    assign idx_last  = (idx_reg == IDX_W'(DEPTH - 1));
    assign cur_valid = slot_valid_reg[idx_reg];
    assign hit       = cur_valid && (mem_rd_data.address == addr_reg);
    assign aged      = cur_valid && (mem_rd_data.misses > limit_reg);
    assign emit_ok   = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptma_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ptma_pkg::ST_READ;
                end
            end
            ptma_pkg::ST_READ:
            begin
                state_next = ptma_pkg::ST_EVAL;
            end
            ptma_pkg::ST_EVAL:
            begin
                if ((action_reg == ptma_pkg::ACT_FOUND) && hit)
                begin
                    state_next = ptma_pkg::ST_IDLE;
                end
                else if ((action_reg == ptma_pkg::ACT_END) && aged && !emit_ok)
                begin
                    state_next = ptma_pkg::ST_EVAL;
                end
                else if (!idx_last)
                begin
                    state_next = ptma_pkg::ST_READ;
                end
                else if (action_reg == ptma_pkg::ACT_BEGIN)
                begin
                    state_next = ptma_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ptma_pkg::ST_FINISH;
                end
            end
            ptma_pkg::ST_FINISH:
            begin
                if (emit_ok)
                begin
                    state_next = ptma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptma_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        slot_valid_next = slot_valid_reg;
        limit_next      = cfg_wr_en ? cfg_wr_data : limit_reg;
        action_next     = action_reg;
        addr_next       = addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_res_next    = out_res_reg;
        out_addr_next   = out_addr_reg;
        out_last_next   = out_last_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = idx_reg;

        case (state_reg)
            ptma_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    action_next     = action;
                    addr_next       = device_address;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                end
            end
            ptma_pkg::ST_READ:
            begin
                mem_rd_en = 1'b1;
            end
            ptma_pkg::ST_EVAL:
            begin
                case (action_reg)
                    ptma_pkg::ACT_BEGIN:
                    begin
                        if (cur_valid && (mem_rd_data.misses != ptma_pkg::MISSES_MAX))
                        begin
                            mem_wr_en          = 1'b1;
                            mem_wr_data.misses = mem_rd_data.misses + 1'b1;
                        end
                    end
                    ptma_pkg::ACT_FOUND:
                    begin
                        if (hit)
                        begin
                            mem_wr_en          = 1'b1;
                            mem_wr_data.misses = '0;
                        end
                        else if (!cur_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    ptma_pkg::ACT_END:
                    begin
                        if (aged && emit_ok)
                        begin
                            slot_valid_next[idx_reg] = 1'b0;
                            out_valid_next = 1'b1;
                            out_res_next   = ptma_pkg::EV_DETACH;
                            out_addr_next  = mem_rd_data.address;
                            out_last_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (!idx_last)
                begin
                    // hold the slot while a detach waits for the output register
                    if (!((action_reg == ptma_pkg::ACT_END) && aged && !emit_ok))
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ptma_pkg::ST_FINISH:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (action_reg == ptma_pkg::ACT_END)
                    begin
                        out_res_next  = ptma_pkg::EV_DONE;
                        out_addr_next = '0;
                    end
                    else if (free_found_reg)
                    begin
                        mem_wr_en           = 1'b1;
                        mem_wr_addr         = free_idx_reg;
                        mem_wr_data.address = addr_reg;
                        mem_wr_data.misses  = '0;
                        slot_valid_next[free_idx_reg] = 1'b1;
                        out_res_next  = ptma_pkg::EV_ATTACH;
                        out_addr_next = addr_reg;
                    end
                    else
                    begin
                        out_res_next  = ptma_pkg::EV_DROP;
                        out_addr_next = addr_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptma_pkg::ST_IDLE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            slot_valid_reg <= '0;
            limit_reg      <= ptma_pkg::MISS_LIMIT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            slot_valid_reg <= slot_valid_next;
            limit_reg      <= limit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        action_reg   <= action_next;
        addr_reg     <= addr_next;
        out_res_reg  <= out_res_next;
        out_addr_reg <= out_addr_next;
        out_last_reg <= out_last_next;
    end

    assign in_stall      = (state_reg != ptma_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign event_res     = out_res_reg;
    assign event_address = out_addr_reg;
    assign last          = out_last_reg;

endmodule

// File: src/presence_table_with_miss_aging.sv
// Presence table with miss aging, top level: slot store plus scan sequencer.
// A request is scanned slot by slot: a read, then a modify/write through the
// single store port pair; found and end requests then emit a closing event,
// and a found address that matches early ends the scan with no event.
// Throughput: one request per scan; detach events wait on a stalled output.
// Reset clears valid bits at once and sets miss_limit to 2; no clearing pass.
`timescale 1ns / 1ps

module presence_table_with_miss_aging #(
    parameter int TABLE_DEPTH = ptma_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [ptma_pkg::ADDR_W-1:0]   device_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    event_res,
    output logic [ptma_pkg::ADDR_W-1:0]   event_address,
    output logic                          last,
    input  logic                          cfg_wr_en,
    input  logic [ptma_pkg::LIMIT_W-1:0]  cfg_wr_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    ptma_pkg::slot_entry_t mem_wr_data;
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    ptma_pkg::slot_entry_t mem_rd_data;

    ptma_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .device_address (device_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .event_address  (event_address),
        .last           (last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

    ptma_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// File: src/ptma_checker.sv
// Port-level checks for the presence table, bound to the top level.
// Depends on ptma_pkg for event and request codes.
`timescale 1ns / 1ps

module ptma_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [1:0]                    action,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    event_res,
    input logic [ptma_pkg::ADDR_W-1:0]   event_address,
    input logic                          last
);

    // a stalled event must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res)
            && $stable(event_address) && $stable(last))
        else $error("event changed while stalled");

    // an end-round request always starts a scan
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ptma_pkg::ACT_END) |=> in_stall)
        else $error("end-round request not scanned");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == ptma_pkg::EV_DONE) |-> last && (event_address == '0))
        else $error("round done malformed");

    a_detach_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == ptma_pkg::EV_DETACH) |-> !last)
        else $error("detach marked last");

    // table entries never hold address zero
    a_addr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != ptma_pkg::EV_DONE) |-> (event_address != '0))
        else $error("event with address zero");

endmodule

bind presence_table_with_miss_aging ptma_checker u_ptma_checker (.*);
